[rtl/mfq_pkg.sv]
// Package with the constants, types and codes of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps

package mfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS  = 3;
    localparam int STORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic ACT_ADD      = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        action;
        logic [7:0]  proc_id;
        logic [15:0] burst;
        logic [1:0]  level;
    } item_t;

    typedef struct packed {
        logic        served_valid;
        logic [7:0]  served_id;
        logic [1:0]  served_level;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic [7:0]  proc_id;
        logic [15:0] burst;
    } record_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

[rtl/multilevel_feedback_queue_scheduler.sv]
// Top level of the multilevel feedback queue scheduler.
// An add beat and a dispatch beat that finds every queue empty stay in idle; their result
// is strobed by done in the cycle after acceptance. A dispatch that finds a process enters
// the POP state, which uses the registered read data of the record memory and writes back
// a demoted record; its result is strobed by done after the POP state. busy is high only
// in the POP state of a dispatch. Results cannot be held off by the receiver.
// The record memory needs no clearing after reset.
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mfq_pkg::item_t    item,
    output logic              done,
    output mfq_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    import mfq_pkg::*;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]    head_next [NUM_LEVELS];
    logic [CNT_W-1:0]    fill_reg [NUM_LEVELS];
    logic [CNT_W-1:0]    fill_next [NUM_LEVELS];
    logic [LVL_W-1:0]    next_lvl_reg, next_lvl_next;
    logic [LVL_W-1:0]    found_reg, found_next;
    logic [15:0]         thresh_reg;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;

    logic                accept;
    logic                found_any;
    logic [LVL_W-1:0]    found_lvl;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    record_t             ram_wdata;
    record_t             ram_rdata;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] fill);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(fill);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] slot);
        return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot);
    endfunction

    function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W:0] lvl);
        if (int'(lvl) >= NUM_LEVELS)
        begin
            return LVL_W'(NUM_LEVELS - 1);
        end
        return LVL_W'(lvl);
    endfunction

    mfq_ram #(
        .WIDTH ($bits(record_t)),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        logic [LVL_W:0] cand;
        found_any = 1'b0;
        found_lvl = '0;
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            cand = (LVL_W+1)'(next_lvl_reg) + (LVL_W+1)'(k);
            if (int'(cand) >= NUM_LEVELS)
            begin
                cand = cand - (LVL_W+1)'(NUM_LEVELS);
            end
            if (!found_any && (fill_reg[LVL_W'(cand)] != '0))
            begin
                found_any = 1'b1;
                found_lvl = LVL_W'(cand);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.action == ACT_DISPATCH) && found_any)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_POP:  busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    always_comb
    begin
        logic [LVL_W-1:0] lvl;
        logic [LVL_W-1:0] dst;
        head_next     = head_reg;
        fill_next     = fill_reg;
        next_lvl_next = next_lvl_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '{proc_id: item.proc_id, burst: item.burst};
        ram_raddr     = addr_of(found_lvl, head_reg[found_lvl]);
        lvl           = sat_level((LVL_W+1)'(item.level));
        dst           = '0;

        if (accept)
        begin
            if (item.action == ACT_ADD)
            begin
                done_next   = 1'b1;
                result_next = '{served_valid: 1'b0, served_id: '0,
                                served_level: '0, status: STATUS_OK};
                if (int'(fill_reg[lvl]) >= QUEUE_DEPTH)
                begin
                    result_next.status = STATUS_FULL;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = addr_of(lvl, slot_of(head_reg[lvl], fill_reg[lvl]));
                    fill_next[lvl] = fill_reg[lvl] + CNT_W'(1);
                end
            end
            else if (!found_any)
            begin
                done_next   = 1'b1;
                result_next = '{served_valid: 1'b0, served_id: '0,
                                served_level: '0, status: STATUS_EMPTY};
            end
            else
            begin
                found_next = found_lvl;
            end
        end
        else if (state_reg == ST_POP)
        begin
            done_next   = 1'b1;
            result_next = '{served_valid: 1'b1, served_id: ram_rdata.proc_id,
                            served_level: 2'(found_reg), status: STATUS_OK};
            if (int'(head_reg[found_reg]) == QUEUE_DEPTH - 1)
            begin
                head_next[found_reg] = '0;
            end
            else
            begin
                head_next[found_reg] = head_reg[found_reg] + PTR_W'(1);
            end
            fill_next[found_reg] = fill_reg[found_reg] - CNT_W'(1);
            next_lvl_next = sat_level((LVL_W+1)'(found_reg) + (LVL_W+1)'(1));
            if (int'(found_reg) == NUM_LEVELS - 1)
            begin
                next_lvl_next = '0;
            end

            if (ram_rdata.burst > thresh_reg)
            begin
                dst = sat_level((LVL_W+1)'(found_reg) + (LVL_W+1)'(1));
                if (int'(fill_next[dst]) >= QUEUE_DEPTH)
                begin
                    result_next.status = STATUS_FULL;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = addr_of(dst, slot_of(head_next[dst], fill_next[dst]));
                    ram_wdata      = ram_rdata;
                    fill_next[dst] = fill_next[dst] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            next_lvl_reg <= '0;
            thresh_reg   <= 16'd2;
            done_reg     <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            next_lvl_reg <= next_lvl_next;
            done_reg     <= done_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        result_reg <= result_next;
    end

    // A dispatch that reached the memory always reports in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (done_reg && result_reg.served_valid))
        else $error("pop cycle did not produce a served result");

    // A served result only comes out of the memory read cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.served_valid) |-> ($past(state_reg) == ST_POP))
        else $error("served result without a memory read");

    // The round-robin pointer always names an existing level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(next_lvl_reg) < NUM_LEVELS))
        else $error("round-robin pointer out of range");

    // A dispatch only reaches the memory read cycle for a nonempty level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (fill_reg[found_reg] != '0))
        else $error("pop from an empty level");

    generate
        for (genvar g = 0; g < NUM_LEVELS; g++)
        begin : g_fill_chk
            assert property (@(posedge clk) disable iff (!rst_n)
                (int'(fill_reg[g]) <= QUEUE_DEPTH))
                else $error("fill count above queue depth");
        end
    endgenerate

endmodule

[rtl/mfq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[bench/testbench.sv]
// Self-checking testbench for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps

module testbench;

    import mfq_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 440;
    localparam int SETTLE_CYCLES   = 4;

    class queue_mirror;
        record_t    lanes[NUM_LEVELS][$];
        int         rr_next;
        logic [15:0] threshold;
        result_t    due_results[$];
        int         error_count;

        function new();
            rr_next     = 0;
            threshold   = 16'd2;
            error_count = 0;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function int held_records();
            int total;
            total = 0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                total += lanes[l].size();
            end
            return total;
        endfunction

        function logic [1:0] enqueue(int lvl, record_t rec);
            if (lanes[lvl].size() >= QUEUE_DEPTH)
            begin
                return STATUS_FULL;
            end
            lanes[lvl].push_back(rec);
            return STATUS_OK;
        endfunction

        function void note_item(item_t it);
            result_t r;
            record_t rec;
            int      lvl;
            int      found;
            int      cand;
            r     = '0;
            found = -1;
            if (it.action == ACT_ADD)
            begin
                lvl = it.level;
                if (lvl >= NUM_LEVELS)
                begin
                    lvl = NUM_LEVELS - 1;
                end
                rec.proc_id = it.proc_id;
                rec.burst   = it.burst;
                r.status    = enqueue(lvl, rec);
            end
            else
            begin
                for (int k = 0; k < NUM_LEVELS; k++)
                begin
                    cand = (rr_next + k) % NUM_LEVELS;
                    if (found < 0 && lanes[cand].size() != 0)
                    begin
                        found = cand;
                    end
                end
                if (found < 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    rec            = lanes[found].pop_front();
                    rr_next        = (found + 1) % NUM_LEVELS;
                    r.served_valid = 1'b1;
                    r.served_id    = rec.proc_id;
                    r.served_level = found[1:0];
                    if (rec.burst > threshold)
                    begin
                        lvl = (found + 1 < NUM_LEVELS) ? found + 1 : NUM_LEVELS - 1;
                        r.status = enqueue(lvl, rec);
                    end
                end
            end
            due_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("unexpected result beat: %h", got);
                error_count++;
                return;
            end
            want = due_results.pop_front();
            if (got.served_valid !== want.served_valid)
            begin
                $error("served_valid: expected %0d, got %0d", want.served_valid, got.served_valid);
                error_count++;
            end
            if (got.served_id !== want.served_id)
            begin
                $error("served_id: expected %0d, got %0d", want.served_id, got.served_id);
                error_count++;
            end
            if (got.served_level !== want.served_level)
            begin
                $error("served_level: expected %0d, got %0d", want.served_level, got.served_level);
                error_count++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                error_count++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    item_t       item      = '0;
    logic        done;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    queue_mirror mirror    = new();
    int          cycle_count = 0;
    int          items_sent  = 0;

    multilevel_feedback_queue_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                mirror.check_result(result);
            end
            if (start && !busy)
            begin
                mirror.note_item(item);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic item_t add_item(logic [7:0] id, logic [15:0] bst, logic [1:0] lvl);
        item_t it;
        it.action  = ACT_ADD;
        it.proc_id = id;
        it.burst   = bst;
        it.level   = lvl;
        return it;
    endfunction

    function automatic item_t dispatch_item();
        item_t it;
        it.action  = ACT_DISPATCH;
        it.proc_id = 8'($urandom);
        it.burst   = 16'($urandom);
        it.level   = 2'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] rand_burst();
        int t;
        int pick;
        t    = mirror.threshold;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return 16'($urandom_range(0, 4));
        end
        else if (pick < 7)
        begin
            return 16'($urandom_range(t > 0 ? t - 1 : 0, t < 65535 ? t + 1 : 65535));
        end
        return 16'($urandom);
    endfunction

    function automatic int next_gap(int pct);
        int g;
        g = 0;
        while (pct > 0 && $urandom_range(0, 99) < pct && g < 20)
        begin
            g++;
        end
        return g;
    endfunction

    task automatic issue(input item_t it, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (mirror.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid        <= 1'b0;
        mirror.threshold = value;
    endtask

    task automatic run_episode(input int phase_pct);
        int pct;
        int kind;
        int n;
        int lvl;
        pct  = ($urandom_range(0, 3) == 0) ? 0 : phase_pct;
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            lvl = $urandom_range(0, 3);
            n   = $urandom_range(4, QUEUE_DEPTH + 3);
            repeat (n) issue(add_item(8'($urandom), rand_burst(), 2'(lvl)), next_gap(pct));
        end
        else if (kind < 7)
        begin
            n = $urandom_range(10, 40);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    issue(add_item(8'($urandom), rand_burst(), 2'($urandom)), next_gap(pct));
                end
                else
                begin
                    issue(dispatch_item(), next_gap(pct));
                end
            end
        end
        else
        begin
            n = mirror.held_records() + $urandom_range(1, 3);
            if (n > 60)
            begin
                n = 60;
            end
            repeat (n) issue(dispatch_item(), next_gap(pct));
        end
    endtask

    logic [15:0] phase_threshold[4];
    int          phase_idle[4];
    int          phase_start;

    initial
    begin
        phase_threshold = '{16'hFFFF, 16'h0000, 16'($urandom_range(1, 1000)), 16'd300};
        phase_idle      = '{0, 59, 0, 20};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(dispatch_item(), 0);
        issue(add_item(8'h00, 16'hFFFF, 2'd0), 0);
        issue(add_item(8'hFF, 16'hFFFF, 2'd3), 0);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
        begin
            issue(add_item(8'(8'h10 + i),
                           (i == 0) ? 16'd2 : (i == 1) ? 16'd3 : 16'($urandom),
                           2'd1), 0);
        end
        repeat (4) issue(dispatch_item(), $urandom_range(0, 1));

        for (int p = 0; p < 4; p++)
        begin
            write_threshold(phase_threshold[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                run_episode(phase_idle[p]);
            end
        end

        settle();
        if (mirror.error_count == 0 && mirror.outstanding() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mfq_pkg.sv
rtl/mfq_ram.sv
rtl/multilevel_feedback_queue_scheduler.sv
bench/testbench.sv
